@@ src/assert_macros.svh @@
// assertion macros used by the checker file
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SHRP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define SHRP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/shrp_pkg.sv @@
// shared types, constants and the per-channel sharpen kernel
// no dependencies; used by the interfaces, top level, window, checker and testbench
package shrp_pkg;

  // field widths
  localparam int CHAN_W     = 8;
  localparam int COORD_W    = 10;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 3 * CHAN_W;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  // register reset values and size floor
  localparam logic [CFG_DATA_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] HEIGHT_RESET = 11'd480;
  localparam int MIN_SIZE = 2;

  // kernel constants
  localparam int KERNEL_TAPS   = 9;
  localparam int KERNEL_CENTER = 4;
  localparam int SHARP_GAIN    = 10;
  localparam int SUM_W         = 12;
  localparam int WIN_REGS      = 6;
  localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'hFF;
  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  // one pixel, blue in the low byte
  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pix_t;

  // one channel of the 3x3 window, row-major
  typedef logic [KERNEL_TAPS-1:0][CHAN_W-1:0] taps_t;

  // window register control from the sequencer
  typedef struct packed {
    logic clear;
    logic shift;
  } win_ctrl_t;

  // results one input can cause, in emission order
  typedef enum logic [1:0] {
    EMIT_LAG,
    EMIT_RIGHT,
    EMIT_BOTTOM
  } emit_e;
  localparam int EMIT_NUM = 3;

  // 9*center - neighbours = 10*center - all nine, clamped to 0..255
  function automatic logic [CHAN_W-1:0] sharpen_chan(input taps_t taps);
    logic [SUM_W-1:0] total;
    logic [SUM_W-1:0] ten;
    logic [SUM_W-1:0] diff;
    logic [CHAN_W-1:0] res;
    total = '0;
    for (int k = 0; k < KERNEL_TAPS; k++) begin
      total = total + SUM_W'(taps[k]);
    end
    ten  = SUM_W'(taps[KERNEL_CENTER]) * SUM_W'(SHARP_GAIN);
    diff = ten - total;
    if (ten < total) begin
      res = '0;
    end else if (diff > SUM_W'(CHAN_MAX)) begin
      res = CHAN_MAX;
    end else begin
      res = diff[CHAN_W-1:0];
    end
    return res;
  endfunction

endpackage

@@ src/shrp_if.sv @@
// handshake channels of the sharpen filter: pixel in, result out, config write
// depends on shrp_pkg
interface shrp_pix_if import shrp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] blue_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] red_in;

  modport source (output valid, blue_in, green_in, red_in, input ready);
  modport sink   (input valid, blue_in, green_in, red_in, output ready);
endinterface

interface shrp_res_if import shrp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] out_x;
  logic [COORD_W-1:0] out_y;
  logic [CHAN_W-1:0]  blue_out;
  logic [CHAN_W-1:0]  green_out;
  logic [CHAN_W-1:0]  red_out;
  logic [CHAN_W-1:0]  alpha_out;
  logic               last_of_run;

  modport source (output valid, out_x, out_y, blue_out, green_out, red_out, alpha_out,
                  last_of_run, input ready);
  modport sink   (input valid, out_x, out_y, blue_out, green_out, red_out, alpha_out,
                  last_of_run, output ready);
endinterface

interface shrp_cfg_if import shrp_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ src/sharpen_3x3_bgra_filter.sv @@
// top level of the 3x3 sharpen filter: counters, line stores, emit sequencer
// depends on shrp_pkg, shrp_if, shrp_ram and shrp_window
//
// Takes BGR pixels in raster order, one per beat, and returns BGRA results
// sharpened with the 3x3 kernel (center 9, neighbours -1), each channel
// clamped to 0..255, alpha 255, and the one-pixel frame border painted opaque
// black. Every result carries its x,y position; row y comes out while row y+1
// arrives and the last row while it arrives, so order differs from raster near
// the right and bottom edges. Each input is registered with the line-store
// read, then the combinational kernel logic fills the output register. While
// the output is not stalled, one pixel is taken every clock in steady state;
// the output port moves one result per beat, so a pixel at the right edge or
// in the last row holds the input while its two or three results leave.
// Writing either size register restarts the frame; line-store contents
// survive and need no clearing pass.
module sharpen_3x3_bgra_filter import shrp_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  shrp_cfg_if.sink   cfg_i,
  shrp_pix_if.sink   pix_i,
  shrp_res_if.source res_o
);

  localparam int CW   = $clog2(MAX_WIDTH);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int CWP  = CW + 1;
  localparam int RWP  = RW + 1;
  localparam int CMPX = (CWP > CFG_DATA_W) ? CWP : CFG_DATA_W;
  localparam int CMPY = (RWP > CFG_DATA_W) ? RWP : CFG_DATA_W;

  // configuration
  logic [CFG_DATA_W-1:0] width_q;
  logic [CFG_DATA_W-1:0] height_q;
  logic                  cfg_write;
  logic                  restart;
  logic [CMPX-1:0]       w_raw;
  logic [CMPX-1:0]       w_ext;
  logic [CMPY-1:0]       h_raw;
  logic [CMPY-1:0]       h_ext;
  logic [CWP-1:0]        w_eff;
  logic [RWP-1:0]        h_eff;

  // raster counters
  logic [CW-1:0]  col_q;
  logic [RW-1:0]  row_q;
  logic           col_at_end;
  logic           row_at_end;

  // input register stage
  logic                s1_valid_q;
  logic                s1_valid_d;
  logic [EMIT_NUM-1:0] s1_pend_q;
  logic [EMIT_NUM-1:0] s1_pend_d;
  logic [EMIT_NUM-1:0] new_pend;
  logic [EMIT_NUM-1:0] pend_rest;
  logic [CW-1:0]       s1_col_q;
  logic [RW-1:0]       s1_row_q;
  logic                s1_inner_q;
  pix_t                s1_px_q;
  pix_t                px_in;
  logic                pix_accept;
  logic                retire;
  emit_e               sel;

  // line stores and window
  pix_t      top_rd;
  pix_t      mid_rd;
  pix_t      sharp;
  win_ctrl_t win_ctrl;

  // result register
  logic               out_valid_q;
  logic               out_valid_d;
  logic               out_free;
  logic               out_load;
  logic [COORD_W-1:0] out_x_q;
  logic [COORD_W-1:0] out_y_q;
  pix_t               out_pix_q;
  logic               out_last_q;
  logic [CW-1:0]      res_x;
  logic [RW-1:0]      res_y;
  pix_t               res_pix;

  // config port always ready; a write to a known register restarts the frame
  assign cfg_i.ready = 1'b1;
  assign cfg_write   = cfg_i.valid && cfg_i.ready;
  assign restart     = cfg_write &&
                       (cfg_i.index == REG_IMAGE_WIDTH || cfg_i.index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WIDTH_RESET;
      height_q <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_i.index)
        REG_IMAGE_WIDTH:  width_q  <= cfg_i.data;
        REG_IMAGE_HEIGHT: height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // sizes clamped to 2..MAX
  always_comb begin
    w_raw = CMPX'(width_q);
    h_raw = CMPY'(height_q);
    priority if (w_raw < CMPX'(MIN_SIZE)) begin
      w_ext = CMPX'(MIN_SIZE);
    end else if (w_raw > CMPX'(MAX_WIDTH)) begin
      w_ext = CMPX'(MAX_WIDTH);
    end else begin
      w_ext = w_raw;
    end
    priority if (h_raw < CMPY'(MIN_SIZE)) begin
      h_ext = CMPY'(MIN_SIZE);
    end else if (h_raw > CMPY'(MAX_HEIGHT)) begin
      h_ext = CMPY'(MAX_HEIGHT);
    end else begin
      h_ext = h_raw;
    end
    w_eff = CWP'(w_ext);
    h_eff = RWP'(h_ext);
  end

  // raster position of the next input pixel
  assign col_at_end = (CWP'(col_q) + CWP'(1)) == w_eff;
  assign row_at_end = (RWP'(row_q) + RWP'(1)) == h_eff;
  assign pix_accept = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_accept) begin
      if (col_at_end) begin
        col_q <= '0;
        row_q <= row_at_end ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // results this pixel will cause
  always_comb begin
    new_pend              = '0;
    new_pend[EMIT_LAG]    = (row_q != '0) && (col_q != '0);
    new_pend[EMIT_RIGHT]  = (row_q != '0) && col_at_end;
    new_pend[EMIT_BOTTOM] = row_at_end;
  end

  assign px_in.blue  = pix_i.blue_in;
  assign px_in.green = pix_i.green_in;
  assign px_in.red   = pix_i.red_in;

  // pick the next pending result in order
  always_comb begin
    pend_rest = s1_pend_q;
    priority if (s1_pend_q[EMIT_LAG]) begin
      sel = EMIT_LAG;
    end else if (s1_pend_q[EMIT_RIGHT]) begin
      sel = EMIT_RIGHT;
    end else begin
      sel = EMIT_BOTTOM;
    end
    pend_rest[sel] = 1'b0;
  end

  assign out_free = !out_valid_q || res_o.ready;
  assign out_load = s1_valid_q && (s1_pend_q != '0) && out_free;
  assign retire   = s1_valid_q && ((s1_pend_q == '0) || (out_load && (pend_rest == '0)));
  assign pix_i.ready = !s1_valid_q || retire;

  // input stage control
  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_pend_d  = s1_pend_q;
    if (pix_accept) begin
      s1_valid_d = 1'b1;
      s1_pend_d  = new_pend;
    end else if (retire) begin
      s1_valid_d = 1'b0;
      s1_pend_d  = '0;
    end else if (out_load) begin
      s1_pend_d  = pend_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_pend_q  <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_pend_q  <= s1_pend_d;
    end
  end

  // input stage payload
  always_ff @(posedge clk_i) begin
    if (pix_accept) begin
      s1_col_q   <= col_q;
      s1_row_q   <= row_q;
      s1_inner_q <= (col_q > CW'(1)) && (row_q > RW'(1));
      s1_px_q    <= px_in;
    end
  end

  // line stores: read on accept, rotate on retire
  shrp_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_upper (
    .clk_i  (clk_i),
    .we_i   (retire),
    .waddr_i(s1_col_q),
    .wdata_i(mid_rd),
    .re_i   (pix_accept),
    .raddr_i(col_q),
    .rdata_o(top_rd)
  );

  shrp_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_middle (
    .clk_i  (clk_i),
    .we_i   (retire),
    .waddr_i(s1_col_q),
    .wdata_i(s1_px_q),
    .re_i   (pix_accept),
    .raddr_i(col_q),
    .rdata_o(mid_rd)
  );

  // window and kernel
  assign win_ctrl.clear = restart;
  assign win_ctrl.shift = retire;

  shrp_window u_window (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (win_ctrl),
    .top_i  (top_rd),
    .mid_i  (mid_rd),
    .px_i   (s1_px_q),
    .sharp_o(sharp)
  );

  // position and colour of the selected result
  always_comb begin
    unique case (sel)
      EMIT_LAG: begin
        res_x   = s1_col_q - CW'(1);
        res_y   = s1_row_q - RW'(1);
        res_pix = s1_inner_q ? sharp : '0;
      end
      EMIT_RIGHT: begin
        res_x   = s1_col_q;
        res_y   = s1_row_q - RW'(1);
        res_pix = '0;
      end
      EMIT_BOTTOM: begin
        res_x   = s1_col_q;
        res_y   = s1_row_q;
        res_pix = '0;
      end
      default: begin
        res_x   = s1_col_q;
        res_y   = s1_row_q;
        res_pix = '0;
      end
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q    <= COORD_W'(res_x);
      out_y_q    <= COORD_W'(res_y);
      out_pix_q  <= res_pix;
      out_last_q <= (pend_rest == '0);
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_x       = out_x_q;
  assign res_o.out_y       = out_y_q;
  assign res_o.blue_out    = out_pix_q.blue;
  assign res_o.green_out   = out_pix_q.green;
  assign res_o.red_out     = out_pix_q.red;
  assign res_o.alpha_out   = ALPHA_OPAQUE;
  assign res_o.last_of_run = out_last_q;

endmodule

@@ src/shrp_ram.sv @@
// generic single-write, single-read RAM with registered read data
// no dependencies
module shrp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/shrp_window.sv @@
// 3x3 window registers and the sharpen kernel on all three colour channels
// depends on shrp_pkg
module shrp_window import shrp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  win_ctrl_t ctrl_i,
  input  pix_t      top_i,
  input  pix_t      mid_i,
  input  pix_t      px_i,
  output pix_t      sharp_o
);

  // [0..2] column c-2, [3..5] column c-1; top, middle, bottom
  pix_t  win_q [WIN_REGS];
  pix_t  tap [KERNEL_TAPS];
  taps_t taps_b;
  taps_t taps_g;
  taps_t taps_r;

  // window shift on retire, cleared on frame restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WIN_REGS; i++) begin
        win_q[i] <= '0;
      end
    end else if (ctrl_i.clear) begin
      for (int i = 0; i < WIN_REGS; i++) begin
        win_q[i] <= '0;
      end
    end else if (ctrl_i.shift) begin
      win_q[0] <= win_q[3];
      win_q[1] <= win_q[4];
      win_q[2] <= win_q[5];
      win_q[3] <= top_i;
      win_q[4] <= mid_i;
      win_q[5] <= px_i;
    end
  end

  // window in row-major order
  always_comb begin
    tap[0] = win_q[0];
    tap[1] = win_q[3];
    tap[2] = top_i;
    tap[3] = win_q[1];
    tap[4] = win_q[4];
    tap[5] = mid_i;
    tap[6] = win_q[2];
    tap[7] = win_q[5];
    tap[8] = px_i;
    for (int k = 0; k < KERNEL_TAPS; k++) begin
      taps_b[k] = tap[k].blue;
      taps_g[k] = tap[k].green;
      taps_r[k] = tap[k].red;
    end
  end

  // per-channel kernel
  assign sharp_o.blue  = sharpen_chan(taps_b);
  assign sharp_o.green = sharpen_chan(taps_g);
  assign sharp_o.red   = sharpen_chan(taps_r);

endmodule

@@ src/shrp_checker.sv @@
// port-level assertions for the sharpen filter, bound to the top level
// depends on shrp_pkg and assert_macros.svh
`include "assert_macros.svh"

module shrp_checker import shrp_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input logic [COORD_W-1:0] out_x_i,
  input logic [COORD_W-1:0] out_y_i,
  input logic [CHAN_W-1:0]  blue_i,
  input logic [CHAN_W-1:0]  green_i,
  input logic [CHAN_W-1:0]  red_i,
  input logic [CHAN_W-1:0]  alpha_i,
  input logic               last_i
);

  // a stalled result beat keeps its position, blue channel and last flag
  `SHRP_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_x_i) && $stable(out_y_i) && $stable(blue_i) && $stable(last_i), "stalled result changed")

  // the rest of a run follows without a gap
  `SHRP_ASSERT_NEXT(a_run_continues, out_valid_i && out_ready_i && !last_i, out_valid_i, "gap inside a run of results")

  // alpha is always opaque
  `SHRP_ASSERT_IMP(a_alpha_opaque, out_valid_i, alpha_i == ALPHA_OPAQUE, "alpha not opaque")

  // top row and left column are painted black
  `SHRP_ASSERT_IMP(a_border_black, out_valid_i && (out_x_i == '0 || out_y_i == '0), blue_i == '0 && green_i == '0 && red_i == '0, "border pixel not black")

endmodule

bind sharpen_3x3_bgra_filter shrp_checker u_shrp_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(res_o.valid),
  .out_ready_i(res_o.ready),
  .out_x_i    (res_o.out_x),
  .out_y_i    (res_o.out_y),
  .blue_i     (res_o.blue_out),
  .green_i    (res_o.green_out),
  .red_i      (res_o.red_out),
  .alpha_i    (res_o.alpha_out),
  .last_i     (res_o.last_of_run)
);

@@ test/tb_sharpen_3x3_bgra_filter.sv @@
// testbench for the 3x3 sharpen filter: drives raster pixels and size writes,
// predicts every BGRA result with its own window model and checks it in order
// depends on shrp_pkg, the shrp_if interfaces and sharpen_3x3_bgra_filter
module tb_sharpen_3x3_bgra_filter;
  timeunit 1ns;
  timeprecision 1ps;
  import shrp_pkg::*;

  localparam int MAX_W        = 1024;
  localparam int MAX_H        = 1024;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_ITEMS = 120;
  localparam int WIDE_ITEMS   = 24;
  localparam int TALL_ITEMS   = 40;
  localparam int HOLD_AFTER   = 40;
  localparam int LONG_HOLD    = 60;
  localparam int TIMEOUT_NS   = 10_000_000;

  // register indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [CHAN_W-1:0]  blue;
    logic [CHAN_W-1:0]  green;
    logic [CHAN_W-1:0]  red;
    logic [CHAN_W-1:0]  alpha;
    logic               last;
  } sharp_res_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  // window model of the filter and the results it still owes
  class sharpen_board;
    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [PIX_W-1:0] upper_line [MAX_W];
    logic [PIX_W-1:0] middle_line [MAX_W];
    logic [PIX_W-1:0] win_regs [WIN_REGS];
    logic [PIX_W-1:0] taps [KERNEL_TAPS];
    int unsigned col_cnt;
    int unsigned row_cnt;
    sharp_res_t due_pixels [$];
    int errors;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      foreach (upper_line[i]) begin
        upper_line[i]  = '0;
        middle_line[i] = '0;
      end
      restart_frame();
      errors = 0;
    endfunction

    function void restart_frame();
      col_cnt = 0;
      row_cnt = 0;
      foreach (win_regs[i]) win_regs[i] = '0;
    endfunction

    function int unsigned frame_size(logic [CFG_DATA_W-1:0] v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function int pending();
      return due_pixels.size();
    endfunction

    // size writes restart the frame, spare indexes do nothing
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_IMAGE_WIDTH: begin
          width_reg = data;
          restart_frame();
        end
        REG_IMAGE_HEIGHT: begin
          height_reg = data;
          restart_frame();
        end
        default: ;
      endcase
    endfunction

    // 10*center minus all nine taps, clamped to one channel
    function logic [CHAN_W-1:0] sharpen_level(int sh);
      int acc;
      acc = SHARP_GAIN * int'(taps[KERNEL_CENTER][sh +: CHAN_W]);
      foreach (taps[k]) acc -= int'(taps[k][sh +: CHAN_W]);
      if (acc < 0) return '0;
      if (acc > int'(CHAN_MAX)) return CHAN_MAX;
      return CHAN_W'(acc);
    endfunction

    function void add_due(int unsigned x, int unsigned y, bit inner);
      sharp_res_t e;
      e.x     = COORD_W'(x);
      e.y     = COORD_W'(y);
      e.blue  = inner ? sharpen_level(0) : '0;
      e.green = inner ? sharpen_level(CHAN_W) : '0;
      e.red   = inner ? sharpen_level(2 * CHAN_W) : '0;
      e.alpha = ALPHA_OPAQUE;
      e.last  = 1'b0;
      due_pixels.push_back(e);
    endfunction

    // one accepted pixel: update line stores and window, queue its results
    function void take_pixel(pix_t p);
      int unsigned w, h, c, r, first;
      logic [PIX_W-1:0] top, mid;
      w = frame_size(width_reg, MAX_W);
      h = frame_size(height_reg, MAX_H);
      if (col_cnt >= w) col_cnt = 0;
      if (row_cnt >= h) row_cnt = 0;
      c = col_cnt;
      r = row_cnt;
      top = upper_line[c];
      mid = middle_line[c];
      upper_line[c]  = mid;
      middle_line[c] = p;
      taps = '{win_regs[0], win_regs[3], top,
               win_regs[1], win_regs[4], mid,
               win_regs[2], win_regs[5], p};
      first = due_pixels.size();
      // row above lags by one column, right edge flushes its last pixel
      if (r >= 1) begin
        if (c >= 1) add_due(c - 1, r - 1, c >= 2 && r >= 2);
        if (c == w - 1) add_due(w - 1, r - 1, 1'b0);
      end
      // bottom row is all border and leaves as it arrives
      if (r == h - 1) add_due(c, h - 1, 1'b0);
      if (due_pixels.size() > first) due_pixels[due_pixels.size() - 1].last = 1'b1;
      win_regs[0] = win_regs[3];
      win_regs[1] = win_regs[4];
      win_regs[2] = win_regs[5];
      win_regs[3] = top;
      win_regs[4] = mid;
      win_regs[5] = p;
      if (c + 1 >= w) begin
        col_cnt = 0;
        row_cnt = (r + 1 >= h) ? 0 : r + 1;
      end else begin
        col_cnt = c + 1;
      end
    endfunction

    function void check_field(string name, logic [COORD_W-1:0] want_v,
                              logic [COORD_W-1:0] got_v);
      if (got_v !== want_v) begin
        $error("%s: expected %0d, got %0d", name, want_v, got_v);
        errors++;
      end
    endfunction

    function void match_result(sharp_res_t got);
      sharp_res_t want;
      if (due_pixels.size() == 0) begin
        $error("result at (%0d,%0d) with no pixel due", got.x, got.y);
        errors++;
        return;
      end
      want = due_pixels.pop_front();
      check_field("out_x", want.x, got.x);
      check_field("out_y", want.y, got.y);
      check_field("blue_out", want.blue, got.blue);
      check_field("green_out", want.green, got.green);
      check_field("red_out", want.red, got.red);
      check_field("alpha_out", want.alpha, got.alpha);
      check_field("last_of_run", want.last, got.last);
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  shrp_cfg_if cfg ();
  shrp_pix_if pix ();
  shrp_res_if res ();

  sharpen_board sb = new();
  reg_write_t reg_writes [$];
  bit sender_steady;

  sharpen_3x3_bgra_filter #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg),
    .pix_i (pix),
    .res_o (res)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  // channels lean toward the rails so the clamp is hit both ways
  function automatic logic [CHAN_W-1:0] pick_level();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return CHAN_MAX;
      default: return CHAN_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic pix_t pick_pixel();
    pix_t p;
    p.blue  = pick_level();
    p.green = pick_level();
    p.red   = pick_level();
    return p;
  endfunction

  // 3x3 frame with one value in the center and another all around
  function automatic pix_t frame_px(int i, logic [CHAN_W-1:0] centre,
                                    logic [CHAN_W-1:0] ring);
    return (i == KERNEL_CENTER) ? {3{centre}} : {3{ring}};
  endfunction

  // one pixel beat, after a random gap
  task automatic send_pixel(input pix_t p);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix.valid    <= 1'b1;
    pix.blue_in  <= p.blue;
    pix.green_in <= p.green;
    pix.red_in   <= p.red;
    do @(posedge clk_i); while (pix.ready !== 1'b1);
  endtask

  task automatic send_pixels(input int unsigned n);
    repeat (n) send_pixel(pick_pixel());
  endtask

  // push out the queued register writes, one beat each
  task automatic write_regs();
    reg_write_t beat;
    while (reg_writes.size() != 0) begin
      beat = reg_writes.pop_front();
      cfg.valid <= 1'b1;
      cfg.index <= beat.index;
      cfg.data  <= beat.data;
      do @(posedge clk_i); while (cfg.ready !== 1'b1);
    end
    cfg.valid <= 1'b0;
  endtask

  // stop offering, wait for every owed result, then let the pipe empty
  task automatic settle();
    pix.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // accepted beats feed the model
  always @(posedge clk_i) begin
    if (cfg.valid && cfg.ready) sb.write_reg(cfg.index, cfg.data);
    if (pix.valid && pix.ready) sb.take_pixel({pix.red_in, pix.green_in, pix.blue_in});
    if (res.valid && res.ready) begin
      sb.match_result('{res.out_x, res.out_y, res.blue_out, res.green_out, res.red_out,
                        res.alpha_out, res.last_of_run});
    end
  end

  // result side: random stalls, one long hold-off once results flow
  initial begin : result_sink
    int hold;
    int taken;
    bit squeezed;
    bit sink_steady;
    res.ready   = 1'b0;
    taken       = 0;
    squeezed    = 1'b0;
    sink_steady = 1'b0;
    forever begin
      if ($urandom_range(0, 49) == 0) sink_steady = !sink_steady;
      hold = sink_steady ? 0 : pick_gap();
      if (!squeezed && taken >= HOLD_AFTER) begin
        hold     = LONG_HOLD;
        squeezed = 1'b1;
      end
      if (hold > 0) begin
        res.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (res.valid !== 1'b1);
      taken++;
    end
  end

  // run limit
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    int unsigned cur_w, cur_h, next_w, next_h, eff_w, eff_h, n, random_items;
    bit whole;
    bit first_pass;
    pix.valid    = 1'b0;
    pix.blue_in  = '0;
    pix.green_in = '0;
    pix.red_in   = '0;
    cfg.valid    = 1'b0;
    cfg.index    = REG_IMAGE_WIDTH;
    cfg.data     = '0;
    sender_steady = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset sizes: the first row owes nothing
    repeat (3) send_pixel(pick_pixel());
    settle();

    // smallest frame with an inner pixel, clamped high; spare writes mid-frame
    reg_writes.push_back('{REG_IMAGE_WIDTH, 11'd3});
    reg_writes.push_back('{REG_IMAGE_HEIGHT, 11'd3});
    write_regs();
    for (int i = 0; i < 4; i++) send_pixel(frame_px(i, CHAN_MAX, 8'h00));
    settle();
    reg_writes.push_back('{REG_SPARE_2, 11'h7FF});
    reg_writes.push_back('{REG_SPARE_3, 11'h000});
    write_regs();
    for (int i = 4; i < 9; i++) send_pixel(frame_px(i, CHAN_MAX, 8'h00));

    // next frame follows by wrap-around, clamped low
    for (int i = 0; i < 9; i++) send_pixel(frame_px(i, 8'h00, CHAN_MAX));
    settle();

    // sizes below the floor become 2x2, all border
    reg_writes.push_back('{REG_IMAGE_WIDTH, 11'd0});
    reg_writes.push_back('{REG_IMAGE_HEIGHT, 11'd1});
    write_regs();
    send_pixels(4);
    settle();

    // widest row through the clamp, start of the first row owes nothing
    reg_writes.push_back('{REG_IMAGE_WIDTH, 11'h7FF});
    reg_writes.push_back('{REG_IMAGE_HEIGHT, 11'd2});
    write_regs();
    send_pixels(WIDE_ITEMS);
    settle();

    // tallest frame through the clamp, narrow rows
    reg_writes.push_back('{REG_IMAGE_WIDTH, 11'd2});
    reg_writes.push_back('{REG_IMAGE_HEIGHT, 11'h7FF});
    write_regs();
    send_pixels(TALL_ITEMS);
    settle();

    // random phases: mostly whole frames at small sizes
    random_items = 0;
    first_pass   = 1'b1;
    cur_w = 2;
    cur_h = 2;
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: next_w = $urandom_range(0, 1);
        1: next_w = $urandom_range(10, 40);
        default: next_w = $urandom_range(2, 9);
      endcase
      next_h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      case (first_pass ? 3 : $urandom_range(0, 5))
        0: begin
          reg_writes.push_back('{REG_IMAGE_WIDTH, CFG_DATA_W'(next_w)});
          cur_w = next_w;
        end
        1: begin
          reg_writes.push_back('{REG_IMAGE_HEIGHT, CFG_DATA_W'(next_h)});
          cur_h = next_h;
        end
        2: begin
          reg_writes.push_back('{($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3),
                                 CFG_DATA_W'($urandom_range(0, 2047))});
        end
        default: begin
          reg_writes.push_back('{REG_IMAGE_WIDTH, CFG_DATA_W'(next_w)});
          reg_writes.push_back('{REG_IMAGE_HEIGHT, CFG_DATA_W'(next_h)});
          cur_w = next_w;
          cur_h = next_h;
        end
      endcase
      first_pass = 1'b0;
      write_regs();
      eff_w = (cur_w < MIN_SIZE) ? MIN_SIZE : cur_w;
      eff_h = (cur_h < MIN_SIZE) ? MIN_SIZE : cur_h;
      whole = ($urandom_range(0, 3) != 0);
      n = whole ? eff_w * eff_h * $urandom_range(1, 2)
                : $urandom_range(1, eff_w * eff_h + eff_w);
      // stay within the item budget
      if (n > RANDOM_ITEMS - random_items) n = RANDOM_ITEMS - random_items;
      sender_steady = ($urandom_range(0, 3) == 0);
      send_pixels(n);
      random_items += n;
      settle();
    end

    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
